// ----- hdl/alarm_tone_sequencer_core_defines.svh -----
// Assertion macros shared by the alarm tone sequencer RTL.
`ifndef ALARM_TONE_SEQUENCER_CORE_DEFINES_SVH
`define ALARM_TONE_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ATS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alarm tone sequencer: assertion failed");

// Next-cycle implication, checked outside reset.
`define ATS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alarm tone sequencer: assertion failed");

`endif

// ----- hdl/ats_pkg.sv -----
// Types, constants and the tone table of the alarm tone sequencer.
package ats_pkg;

  localparam int HOUR_W   = 5;
  localparam int MINSEC_W = 6;
  localparam int HZ_W     = 11;
  localparam int IDX_W    = 3;
  localparam int PAUSE_W  = 2;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_ARM  = 1'b1;

  localparam logic [1:0] REG_HOUR   = 2'd0;
  localparam logic [1:0] REG_MINUTE = 2'd1;
  localparam logic [1:0] REG_SECOND = 2'd2;

  typedef struct packed {
    logic                armed;
    logic                running;
    logic                in_pause;
    logic [IDX_W-1:0]    tone_index;
    logic [IDX_W-1:0]    round_index;
    logic [PAUSE_W-1:0]  pause_ticks;
  } ats_state_t;

  typedef struct packed {
    logic                func;
    logic [HOUR_W-1:0]   now_hour;
    logic [MINSEC_W-1:0] now_minute;
    logic [MINSEC_W-1:0] now_second;
    logic                button_down;
  } ats_item_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINSEC_W-1:0] minute;
    logic [MINSEC_W-1:0] second;
  } ats_alarm_t;

  typedef struct packed {
    logic [IDX_W-1:0]    round_count;
    logic [IDX_W-1:0]    tone_step;
    logic                fired;
    logic [HZ_W-1:0]     tone_hz;
    logic                buzzer_on;
    logic                led_on;
    logic                relay_on;
  } ats_result_t;

  function automatic logic [HZ_W-1:0] tone_freq(input logic [IDX_W-1:0] idx);
    logic [HZ_W-1:0] f;
    case (idx)
      3'd0:    f = 11'd1000;
      3'd1:    f = 11'd1200;
      3'd2:    f = 11'd800;
      3'd3:    f = 11'd1500;
      3'd4:    f = 11'd1000;
      3'd5:    f = 11'd1200;
      3'd6:    f = 11'd900;
      default: f = 11'd1000;
    endcase
    return f;
  endfunction

endpackage

// ----- hdl/ats_step.sv -----
// Next-state and result logic for one accepted item.
module ats_step
  import ats_pkg::*;
#(
  parameter int TONE_COUNT   = 7,
  parameter int ROUND_COUNT  = 6,
  parameter int PAUSE_LENGTH = 3
) (
  input  ats_state_t  state,
  input  ats_item_t   item,
  input  ats_alarm_t  alarm,
  output ats_state_t  state_next,
  output ats_result_t result
);

  localparam logic [IDX_W:0]     TONE_LIMIT  = (IDX_W+1)'(TONE_COUNT);
  localparam logic [IDX_W:0]     ROUND_LIMIT = (IDX_W+1)'(ROUND_COUNT);
  localparam logic [PAUSE_W-1:0] PAUSE_LOAD  = PAUSE_W'(PAUSE_LENGTH - 1);

  logic [IDX_W:0] tone_inc;
  logic [IDX_W:0] round_inc;
  logic           match;
  logic           fire;
  logic           tone_phase;

  assign tone_inc  = {1'b0, state.tone_index} + 1'b1;
  assign round_inc = {1'b0, state.round_index} + 1'b1;
  assign match = (item.now_hour == alarm.hour) && (item.now_minute == alarm.minute) &&
                 (item.now_second == alarm.second);

  always_comb begin
    state_next = state;
    fire       = 1'b0;
    if (item.func == FUNC_ARM) begin
      state_next.armed = 1'b1;
    end else if (state.running) begin
      if (state.in_pause) begin
        if (state.pause_ticks == '0) begin
          if (round_inc >= ROUND_LIMIT) begin
            state_next = '{armed: state.armed, default: '0};
          end else begin
            state_next.round_index = round_inc[IDX_W-1:0];
            state_next.tone_index  = '0;
            state_next.in_pause    = 1'b0;
          end
        end else begin
          state_next.pause_ticks = state.pause_ticks - 1'b1;
        end
      end else if (item.button_down) begin
        // stop skips the pause
        state_next = '{armed: state.armed, default: '0};
      end else if (tone_inc >= TONE_LIMIT) begin
        state_next.in_pause    = 1'b1;
        state_next.pause_ticks = PAUSE_LOAD;
      end else begin
        state_next.tone_index = tone_inc[IDX_W-1:0];
      end
    end else if (state.armed && match) begin
      fire       = 1'b1;
      state_next = '{running: 1'b1, default: '0};
    end
  end

  assign tone_phase = state_next.running && !state_next.in_pause;

  assign result.relay_on    = state_next.running;
  assign result.led_on      = tone_phase;
  assign result.buzzer_on   = tone_phase;
  assign result.tone_hz     = tone_phase ? tone_freq(state_next.tone_index) : '0;
  assign result.fired       = fire;
  assign result.tone_step   = state_next.tone_index;
  assign result.round_count = state_next.round_index;

endmodule

// ----- hdl/alarm_tone_sequencer_core.sv -----
// Alarm time comparator and tone sequencer top level with stream ports.
// One item is accepted per clock cycle; its result appears in the output register on
// the next cycle. The only thing that slows intake is the output register: while a
// result waits with m_tready low, s_tready is low. Arm items (s_tuser = 1) set the
// armed flag; tick items (s_tuser = 0) compare the time and advance the tone sequence.
// Alarm registers are written through cfg_we/cfg_index/cfg_data (0 hour, 1 minute,
// 2 second) and should only change while no transfer is in flight.
`include "alarm_tone_sequencer_core_defines.svh"

module alarm_tone_sequencer_core
  import ats_pkg::*;
#(
  parameter int TONE_COUNT   = 7,
  parameter int ROUND_COUNT  = 6,
  parameter int PAUSE_LENGTH = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_hour[4:0], now_minute[10:5], now_second[16:11], button_down[17], zero pad
  input  logic [23:0] s_tdata,
  // func[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // relay_on[0], led_on[1], buzzer_on[2], tone_hz[13:3], fired[14],
  // tone_step[17:15], round_count[20:18], zero pad
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  ats_state_t  state;
  ats_state_t  state_next;
  ats_alarm_t  alarm;
  ats_item_t   item;
  ats_result_t result;
  ats_result_t out_reg;
  logic        s_accept;

  assign item = '{func:        s_tuser,
                  now_hour:    s_tdata[4:0],
                  now_minute:  s_tdata[10:5],
                  now_second:  s_tdata[16:11],
                  button_down: s_tdata[17]};

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOUR:   alarm.hour   <= cfg_data[HOUR_W-1:0];
        REG_MINUTE: alarm.minute <= cfg_data;
        REG_SECOND: alarm.second <= cfg_data;
        default:    ;
      endcase
    end
  end

  ats_step #(
    .TONE_COUNT   (TONE_COUNT),
    .ROUND_COUNT  (ROUND_COUNT),
    .PAUSE_LENGTH (PAUSE_LENGTH)
  ) u_step (
    .state      (state),
    .item       (item),
    .alarm      (alarm),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_accept) begin
        state <= state_next;
      end
      if (s_accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {3'b000, out_reg};

  `ATS_ASSERT_IMP(a_idle_clean, !state.running,
                  !state.in_pause && state.tone_index == '0 && state.round_index == '0)
  `ATS_ASSERT_IMP(a_fired_tone, m_tvalid && out_reg.fired,
                  out_reg.relay_on && out_reg.led_on && !state.armed)
  `ATS_ASSERT_NXT(a_arm_sets, s_accept && s_tuser == FUNC_ARM, state.armed)
  `ATS_ASSERT_IMP(a_silent_off, m_tvalid && !out_reg.led_on,
                  out_reg.tone_hz == '0 && !out_reg.buzzer_on)

endmodule
